>>> sv/toeq_pkg.sv
// ----------------------------------------------------------------------------
// toeq_pkg
// shared types, constants and ring helpers of the time-ordered event queue
// ----------------------------------------------------------------------------
package toeq_pkg;

  localparam int QueueDepth = 64;
  localparam int AddrW      = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int TimeW      = 32;
  localparam int TaskW      = 6;
  localparam int KindW      = 3;
  localparam int StatusW    = 2;
  localparam int FillW      = 7;

  localparam logic ActInsert = 1'b0;
  localparam logic ActPop    = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [KindW-1:0] event_kind;
    logic [TaskW-1:0] task_id;
    logic [TimeW-1:0] event_time;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic              wr_en;
    logic [AddrW-1:0]  wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [AddrW-1:0]  rd_addr;
  } ram_req_t;

  typedef struct packed {
    status_e           status;
    entry_t            head;
    logic [FillW-1:0]  fill_level;
  } result_t;

  function automatic logic [AddrW-1:0] ring_prev(input logic [AddrW-1:0] p);
    ring_prev = (p == '0) ? AddrW'(QueueDepth - 1) : p - 1'b1;
  endfunction

  function automatic logic [AddrW-1:0] ring_next(input logic [AddrW-1:0] p);
    ring_next = (p == AddrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

>>> sv/toeq_ram.sv
// ----------------------------------------------------------------------------
// toeq_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module toeq_ram #(
  parameter int Depth = 64,
  parameter int Width = 8,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/toeq_ctrl.sv
// ----------------------------------------------------------------------------
// toeq_ctrl
// sequencer with one shared compare-and-move unit walking back from the tail
// ----------------------------------------------------------------------------
module toeq_ctrl import toeq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     action_i,
  input  entry_t   in_entry_i,
  input  logic     urgent_i,
  output ram_req_t ram_req_o,
  input  entry_t   ram_rd_data_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output result_t  res_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCmp   = 2'd1;
  localparam logic [1:0] StPlace = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] gap_q, gap_d;
  logic [CntW-1:0]  left_q, left_d;
  entry_t           new_q, new_d;
  logic             urg_q, urg_d;
  status_e          status_q, status_d;
  logic             pop_q, pop_d;
  logic [AddrW-1:0] src;
  logic             stop;

  assign src  = ring_prev(gap_q);
  assign stop = (ram_rd_data_i.event_time < new_q.event_time) ||
                (!urg_q && (ram_rd_data_i.event_time == new_q.event_time));

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    gap_d       = gap_q;
    left_d      = left_q;
    new_d       = new_q;
    urg_d       = urg_q;
    status_d    = status_q;
    pop_d       = pop_q;
    ram_req_o   = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = StFin;
          pop_d   = 1'b0;
          if (action_i == ActPop) begin
            if (cnt_q == '0) begin
              status_d = STATUS_EMPTY;
            end else begin
              status_d          = STATUS_DONE;
              pop_d             = 1'b1;
              ram_req_o.rd_en   = 1'b1;
              ram_req_o.rd_addr = head_q;
              head_d            = ring_next(head_q);
              cnt_d             = cnt_q - 1'b1;
            end
          end else begin
            new_d = in_entry_i;
            urg_d = urgent_i;
            gap_d = tail_q;
            if (cnt_q == CntW'(QueueDepth)) begin
              status_d = STATUS_FULL;
            end else if (cnt_q == '0) begin
              status_d = STATUS_DONE;
              state_d  = StPlace;
            end else begin
              status_d          = STATUS_DONE;
              ram_req_o.rd_en   = 1'b1;
              ram_req_o.rd_addr = ring_prev(tail_q);
              left_d            = cnt_q;
              state_d           = StCmp;
            end
          end
        end
      end
      StCmp: begin
        ram_req_o.wr_en   = 1'b1;
        ram_req_o.wr_addr = gap_q;
        if (stop) begin
          ram_req_o.wr_data = new_q;
          tail_d            = ring_next(tail_q);
          cnt_d             = cnt_q + 1'b1;
          state_d           = StFin;
        end else begin
          ram_req_o.wr_data = ram_rd_data_i;
          gap_d             = src;
          left_d            = left_q - 1'b1;
          if (left_q == CntW'(1)) begin
            state_d = StPlace;
          end else begin
            ram_req_o.rd_en   = 1'b1;
            ram_req_o.rd_addr = ring_prev(src);
          end
        end
      end
      StPlace: begin
        ram_req_o.wr_en   = 1'b1;
        ram_req_o.wr_addr = gap_q;
        ram_req_o.wr_data = new_q;
        tail_d            = ring_next(tail_q);
        cnt_d             = cnt_q + 1'b1;
        state_d           = StFin;
      end
      StFin: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    res_o.status     = status_q;
    res_o.head       = pop_q ? ram_rd_data_i : '0;
    res_o.fill_level = FillW'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      pop_q   <= pop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gap_q    <= gap_d;
    left_q   <= left_d;
    new_q    <= new_d;
    urg_q    <= urg_d;
    status_q <= status_d;
  end

endmodule

>>> sv/time_ordered_event_queue_top.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue_top
// event list of a discrete-event simulator, kept sorted by time in a ring
// ----------------------------------------------------------------------------
// input items on s_axis: tuser carries the action (insert or pop), tdata the
// event time, task, kind and urgent flag. every input item gives exactly one
// result item on m_axis: status in tuser, popped entry and fill level in
// tdata (head fields zero unless a pop succeeded).
// an insert walks back from the tail with one compare-and-move step per
// cycle over a single-port-read ram, moving 0 to 63 entries. a pop, a full
// insert or an empty pop goes from idle straight to the result state.
// s_axis_tready_o is high only while no item is in progress.
// the result sits in an output register; a stalled receiver holds it and
// the block still takes the next item, finishing it and waiting until the
// register is free.
// reset empties the queue (head, tail and count cleared); the ram contents
// are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_top import toeq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // event_time[31:0], task_id[37:32], event_kind[40:38], urgent[41], zero pad
  input  logic [47:0] s_axis_tdata_i,
  // action[0]
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // head_time[31:0], head_task[37:32], head_kind[40:38], fill_level[47:41]
  output logic [47:0] m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]  m_axis_tuser_o
);

  entry_t   in_entry;
  ram_req_t ram_req;
  entry_t   ram_rd_data;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  logic     out_vld_q;
  result_t  out_q;

  assign in_entry.event_time = s_axis_tdata_i[TimeW-1:0];
  assign in_entry.task_id    = s_axis_tdata_i[TimeW+TaskW-1:TimeW];
  assign in_entry.event_kind = s_axis_tdata_i[TimeW+TaskW+KindW-1:TimeW+TaskW];

  toeq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .action_i      (s_axis_tuser_i[0]),
    .in_entry_i    (in_entry),
    .urgent_i      (s_axis_tdata_i[TimeW+TaskW+KindW]),
    .ram_req_o     (ram_req),
    .ram_rd_data_i (ram_rd_data),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  toeq_ram #(
    .Depth (QueueDepth),
    .Width (EntryW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign res_ready = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {out_q.fill_level, out_q.head.event_kind,
                            out_q.head.task_id, out_q.head.event_time};

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the time-ordered event queue
// ----------------------------------------------------------------------------
// a queue of insert and pop items feeds a clocked driver on the input stream,
// and a clocked monitor takes result items from the output stream. each
// accepted item goes through a shadow copy of the sorted ring, which holds
// the expected result. the monitor compares every result item with the
// oldest expected one. both sides idle and stall at random. directed items
// cover empty pops, field extremes and equal-time ordering. random episodes
// fill the queue past full and drain it past empty, or mix inserts and pops
// over wide, narrow and extreme time ranges.
// ----------------------------------------------------------------------------
module tb import toeq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 500000;
  localparam int DrainWait  = 80;

  typedef struct {
    logic             action;
    logic [TimeW-1:0] ev_time;
    logic [TaskW-1:0] task_id;
    logic [KindW-1:0] kind;
    logic             urgent;
    bit               drain_first;
  } event_op_t;

  typedef struct packed {
    status_e          status;
    logic [TimeW-1:0] head_time;
    logic [TaskW-1:0] head_task;
    logic [KindW-1:0] head_kind;
    logic [FillW-1:0] fill;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;

  event_op_t queued_ops[$];
  outcome_t  expected_outcomes[$];
  event_op_t cur_op;

  logic [TimeW-1:0] sh_time[QueueDepth];
  logic [TaskW-1:0] sh_task[QueueDepth];
  logic [KindW-1:0] sh_kind[QueueDepth];
  int sh_head = 0;
  int sh_tail = 0;
  int sh_count = 0;

  int  n_bad = 0;
  int  cycles = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  bit  calm_tx = 1'b0;
  bit  calm_rx = 1'b0;

  time_ordered_event_queue_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #10 clk_i = ~clk_i;

  task automatic predict_event_op(input event_op_t op);
    outcome_t o;
    int gap;
    int src;
    int left;
    o = '0;
    o.status = STATUS_DONE;
    if (op.action == ActInsert) begin
      if (sh_count >= QueueDepth) begin
        o.status = STATUS_FULL;
      end else begin
        gap = sh_tail;
        left = sh_count;
        while (left > 0) begin
          src = (gap + QueueDepth - 1) % QueueDepth;
          if (sh_time[src] < op.ev_time || (!op.urgent && sh_time[src] == op.ev_time)) break;
          sh_time[gap] = sh_time[src];
          sh_task[gap] = sh_task[src];
          sh_kind[gap] = sh_kind[src];
          gap = src;
          left--;
        end
        sh_time[gap] = op.ev_time;
        sh_task[gap] = op.task_id;
        sh_kind[gap] = op.kind;
        sh_tail = (sh_tail + 1) % QueueDepth;
        sh_count++;
      end
    end else begin
      if (sh_count == 0) begin
        o.status = STATUS_EMPTY;
      end else begin
        o.head_time = sh_time[sh_head];
        o.head_task = sh_task[sh_head];
        o.head_kind = sh_kind[sh_head];
        sh_head = (sh_head + 1) % QueueDepth;
        sh_count--;
      end
    end
    o.fill = FillW'(sh_count);
    expected_outcomes.push_back(o);
  endtask

  function automatic logic [TimeW-1:0] pick_tick(input int style, input logic [TimeW-1:0] base);
    case (style)
      0: return $urandom;
      1: return base + $urandom_range(0, 7);
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return 32'd1;
          2: return '1;
          default: return 32'hFFFF_FFFE;
        endcase
      end
    endcase
  endfunction

  task automatic add_insert(input logic [TimeW-1:0] t, input logic [TaskW-1:0] id,
                            input logic [KindW-1:0] k, input logic u, input bit drain);
    event_op_t op;
    op.action = ActInsert;
    op.ev_time = t;
    op.task_id = id;
    op.kind = k;
    op.urgent = u;
    op.drain_first = drain;
    queued_ops.push_back(op);
  endtask

  // pops carry random payload, which the block ignores
  task automatic add_pop(input bit drain);
    event_op_t op;
    op.action = ActPop;
    op.ev_time = $urandom;
    op.task_id = TaskW'($urandom_range(0, 63));
    op.kind = KindW'($urandom_range(0, 7));
    op.urgent = 1'($urandom_range(0, 1));
    op.drain_first = drain;
    queued_ops.push_back(op);
  endtask

  always @(posedge clk_i) begin : drive_ops
    logic hold_valid;
    if (rst_ni) begin
      hold_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_event_op(cur_op);
        hold_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) calm_tx = !calm_tx;
        tx_wait = calm_tx ? 0 : $urandom_range(0, 6);
      end
      if (!hold_valid) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (queued_ops.size() > 0 &&
                     !(queued_ops[0].drain_first && expected_outcomes.size() != 0)) begin
          cur_op = queued_ops.pop_front();
          s_tdata <= {6'b0, cur_op.urgent, cur_op.kind, cur_op.task_id, cur_op.ev_time};
          s_tuser <= cur_op.action;
          hold_valid = 1'b1;
        end
      end
      s_tvalid <= hold_valid;
    end
  end

  always @(posedge clk_i) begin : watch_results
    outcome_t seen;
    outcome_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        seen.status = status_e'(m_tuser);
        seen.head_time = m_tdata[31:0];
        seen.head_task = m_tdata[37:32];
        seen.head_kind = m_tdata[40:38];
        seen.fill = m_tdata[47:41];
        if (expected_outcomes.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result item: status %0d time %h task %0d kind %0d fill %0d",
                     seen.status, seen.head_time, seen.head_task, seen.head_kind, seen.fill);
        end else begin
          want = expected_outcomes.pop_front();
          if (seen !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"mismatch at %0t: status %0d/%0d time %h/%h task %0d/%0d ",
                        "kind %0d/%0d fill %0d/%0d (expected/actual)"}, $realtime,
                       want.status, seen.status, want.head_time, seen.head_time,
                       want.head_task, seen.head_task, want.head_kind, seen.head_kind,
                       want.fill, seen.fill);
          end
        end
        if ($urandom_range(0, 39) == 0) calm_rx = !calm_rx;
        rx_wait = calm_rx ? 0 : $urandom_range(0, 6);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL time_ordered_event_queue_top");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int n;
    int style;
    int pins;
    bit first;
    logic [TimeW-1:0] t;
    logic [TimeW-1:0] base;

    // empty pop, extremes, equal times with and without urgency
    add_pop(1'b1);
    add_insert('0, 6'd0, 3'd0, 1'b0, 1'b0);
    add_insert('1, 6'd63, 3'd7, 1'b1, 1'b0);
    add_insert(32'd100, 6'd1, 3'd1, 1'b0, 1'b0);
    add_insert(32'd100, 6'd2, 3'd2, 1'b0, 1'b0);
    add_insert(32'd100, 6'd3, 3'd3, 1'b1, 1'b0);
    add_insert(32'd100, 6'd4, 3'd4, 1'b1, 1'b0);
    add_insert(32'h5555_5555, 6'h2a, 3'd2, 1'b0, 1'b0);
    add_insert(32'hAAAA_AAAA, 6'h15, 3'd5, 1'b1, 1'b0);
    add_insert('0, 6'd9, 3'd6, 1'b1, 1'b0);
    repeat (12) add_pop(1'b0);

    first = 1'b1;
    while (queued_ops.size() < 1225) begin
      if (first || $urandom_range(0, 9) == 0) begin
        // fill past full, then drain past empty
        style = first ? 0 : $urandom_range(0, 2);
        first = 1'b0;
        t = $urandom;
        base = $urandom;
        n = QueueDepth + $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          case (style)
            0: t = t - $urandom_range(0, 3);
            1: t = t + $urandom_range(0, 3);
            default: t = pick_tick($urandom_range(0, 2), base);
          endcase
          add_insert(t, TaskW'($urandom_range(0, 63)), KindW'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), i == 0);
        end
        n = QueueDepth + $urandom_range(1, 3);
        for (i = 0; i < n; i++) add_pop(i == 0 && $urandom_range(0, 1) == 1);
      end else begin
        n = $urandom_range(20, 60);
        pins = $urandom_range(30, 70);
        style = $urandom_range(0, 2);
        base = $urandom;
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 99) < pins)
            add_insert(pick_tick(style, base), TaskW'($urandom_range(0, 63)),
                       KindW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b0);
          else
            add_pop(1'b0);
        end
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (queued_ops.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (n_bad == 0 && expected_outcomes.size() == 0) begin
      $display("PASS time_ordered_event_queue_top");
    end else begin
      $display("FAIL time_ordered_event_queue_top");
    end
    $finish;
  end

endmodule
